// File: rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and codes for the sorted priority queue: operation and status
// codes, the request and response payloads, and the cell data types.
// ============================================================================
`default_nettype none

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // operation codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_cell_ctl;

    // one result beat
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] highest_priority;
        logic signed [DATA_W-1:0] lowest_priority;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/spq_ifs.sv
// ============================================================================
// spq request and response channels
// Valid/ready channels for operation beats into the queue and result beats
// out of it.
// ============================================================================
`default_nettype none

interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [spq_pkg::DATA_W-1:0]   value;
    logic signed [spq_pkg::DATA_W-1:0]   priority_req;

    modport source (output valid, kind, value, priority_req, input ready);
    modport sink   (input valid, kind, value, priority_req, output ready);
endinterface

interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [spq_pkg::DATA_W-1:0]   removed_value;
    logic signed [spq_pkg::DATA_W-1:0]   front_value;
    logic signed [spq_pkg::DATA_W-1:0]   highest_priority;
    logic signed [spq_pkg::DATA_W-1:0]   lowest_priority;
    logic [spq_pkg::OCC_W-1:0]           occupancy;
    logic                                is_empty;

    modport source (output valid, status, removed_value, front_value, highest_priority,
                    lowest_priority, occupancy, is_empty, input ready);
    modport sink   (input valid, status, removed_value, front_value, highest_priority,
                    lowest_priority, occupancy, is_empty, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted store. Compares its priority with the broadcast
// entry and either holds, takes the new entry, or shifts from a neighbor.
// ============================================================================
`default_nettype none

module spq_cell (
    input  wire                 i_clk,
    input  spq_pkg::t_cell_ctl  i_ctl,
    input  wire                 i_occ,
    input  wire                 i_prev_ge,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    output logic                o_ge,
    output spq_pkg::t_entry     o_entry,
    output spq_pkg::t_entry     o_next
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // stored entry of greater or equal priority stays ahead of a new one
    assign o_ge = i_occ && (r_entry.prio >= i_ctl.entry.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (!o_ge) begin
                n_entry = i_prev_ge ? i_ctl.entry : i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

`default_nettype wire

// File: rtl/stable_priority_queue_unit.sv
// ============================================================================
// stable_priority_queue_unit
// Bounded priority queue kept sorted in a row of cells, stable for ties.
// ============================================================================
// usage:
//   i_req carries one operation per beat: kind 0 enqueues value with
//   priority_req, kind 1 removes the front entry. o_rsp returns exactly one
//   result beat per operation, describing the queue after it: status,
//   removed value, front value, front and rear priority, occupancy, empty.
//   every cell compares its priority with the new entry in parallel, so an
//   insert or a removal completes in the cycle that accepts it; the result
//   appears in the output register in the cycle after the beat is taken.
//   throughput is one operation per cycle while i_req.ready stays high.
//   the output register decouples the sides: a new beat is taken while the
//   previous result is being taken; if the receiver stalls, the result is
//   held and i_req.ready drops until it leaves.
//   a synchronous reset empties the queue; stored data is not cleared.
//   a full enqueue or an empty dequeue leaves the queue untouched and
//   reports status 2 or 1.
// ============================================================================
`default_nettype none

module stable_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic signed [spq_pkg::DATA_W-1:0] r_lowest;
    logic signed [spq_pkg::DATA_W-1:0] n_lowest;
    logic                r_out_valid;
    logic                n_out_valid;
    spq_pkg::t_rsp       r_rsp;
    spq_pkg::t_rsp       n_rsp;

    logic                accept;
    logic                full;
    logic                empty;
    logic                all_ge;
    spq_pkg::t_cell_ctl  ctl;
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] ge;
    spq_pkg::t_entry     cur  [CAPACITY];
    spq_pkg::t_entry     nxt  [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(CAPACITY));
    assign empty       = (r_count == '0);

    assign ctl.push        = accept && (i_req.kind == spq_pkg::KIND_ENQ) && !full;
    assign ctl.pop         = accept && (i_req.kind == spq_pkg::KIND_DEQ) && !empty;
    assign ctl.entry.value = i_req.value;
    assign ctl.entry.prio  = i_req.priority_req;

    // new entry lands at the rear when every occupied cell stays ahead
    assign all_ge = &(ge | ~occ);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occ[g] = (r_count > CNT_W'(g));

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_occ     (occ[g]),
            .i_prev_ge ((g == 0) ? 1'b1 : ge[(g == 0) ? 0 : g - 1]),
            .i_left    ((g == 0) ? ctl.entry : cur[(g == 0) ? 0 : g - 1]),
            .i_right   ((g == CAPACITY - 1) ? cur[g] : cur[(g == CAPACITY - 1) ? g : g + 1]),
            .o_ge      (ge[g]),
            .o_entry   (cur[g]),
            .o_next    (nxt[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_lowest = r_lowest;
        if (ctl.push) begin
            n_count = r_count + 1'b1;
            if (all_ge) begin
                n_lowest = i_req.priority_req;
            end
        end else if (ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_rsp = r_rsp;
        if (accept) begin
            n_rsp.status = spq_pkg::STATUS_OK;
            if (i_req.kind == spq_pkg::KIND_ENQ && full) begin
                n_rsp.status = spq_pkg::STATUS_FULL;
            end else if (i_req.kind == spq_pkg::KIND_DEQ && empty) begin
                n_rsp.status = spq_pkg::STATUS_EMPTY;
            end
            n_rsp.removed_value    = ctl.pop ? cur[0].value : '0;
            n_rsp.is_empty         = (n_count == '0);
            n_rsp.front_value      = n_rsp.is_empty ? '0 : nxt[0].value;
            n_rsp.highest_priority = n_rsp.is_empty ? '0 : nxt[0].prio;
            n_rsp.lowest_priority  = n_rsp.is_empty ? '0 : n_lowest;
            n_rsp.occupancy        = spq_pkg::OCC_W'(n_count);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lowest <= n_lowest;
        r_rsp    <= n_rsp;
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_rsp.status;
    assign o_rsp.removed_value    = r_rsp.removed_value;
    assign o_rsp.front_value      = r_rsp.front_value;
    assign o_rsp.highest_priority = r_rsp.highest_priority;
    assign o_rsp.lowest_priority  = r_rsp.lowest_priority;
    assign o_rsp.occupancy        = r_rsp.occupancy;
    assign o_rsp.is_empty         = r_rsp.is_empty;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |=> r_count == $past(r_count) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.kind == spq_pkg::KIND_ENQ) && full
        |=> r_rsp.status == spq_pkg::STATUS_FULL && r_count == $past(r_count))
        else $error("full enqueue not rejected");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> cur[0].prio >= cur[1].prio)
        else $error("front cells out of order");

    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_rsp.is_empty == (r_count == '0))
        else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire

// File: tb/stable_priority_queue_unit_tb.sv
// ============================================================================
// stable_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue. A tracker class keeps
// its own sorted copy of the queue, predicts one snapshot per accepted
// operation and compares every result beat field by field. Stimulus is a
// short directed run (empty dequeue, extreme priorities, ties, full enqueue)
// followed by random bursts that swing the queue between empty and full
// under varying idle rates on both sides.
// ============================================================================

class sorted_queue_tracker #(int SLOTS = 16);

    logic signed [31:0] slot_value [SLOTS];
    logic signed [31:0] slot_prio  [SLOTS];
    int                 fill;
    spq_pkg::t_rsp      pending_snapshots [$];
    int unsigned        beat_index;
    int unsigned        mismatch_count;

    function new();
        fill           = 0;
        beat_index     = 0;
        mismatch_count = 0;
    endfunction

    function int pending();
        return pending_snapshots.size();
    endfunction

    // apply one accepted operation and queue the snapshot it should produce
    function void note_operation(logic kind, logic signed [31:0] value,
                                 logic signed [31:0] prio);
        spq_pkg::t_rsp snap;
        int            pos;
        snap = '0;
        snap.status = spq_pkg::STATUS_OK;
        if (kind == spq_pkg::KIND_ENQ) begin
            if (fill >= SLOTS) begin
                snap.status = spq_pkg::STATUS_FULL;
            end else begin
                // stable insert: goes behind every entry of greater or equal priority
                pos = 0;
                while (pos < fill && slot_prio[pos] >= prio)
                    pos++;
                for (int i = fill; i > pos; i--) begin
                    slot_value[i] = slot_value[i-1];
                    slot_prio[i]  = slot_prio[i-1];
                end
                slot_value[pos] = value;
                slot_prio[pos]  = prio;
                fill++;
            end
        end else begin
            if (fill == 0) begin
                snap.status = spq_pkg::STATUS_EMPTY;
            end else begin
                snap.removed_value = slot_value[0];
                for (int i = 0; i + 1 < fill; i++) begin
                    slot_value[i] = slot_value[i+1];
                    slot_prio[i]  = slot_prio[i+1];
                end
                fill--;
            end
        end
        if (fill > 0) begin
            snap.front_value      = slot_value[0];
            snap.highest_priority = slot_prio[0];
            snap.lowest_priority  = slot_prio[fill-1];
            snap.is_empty         = 1'b0;
        end else begin
            snap.is_empty = 1'b1;
        end
        snap.occupancy = fill[4:0];
        pending_snapshots.push_back(snap);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task compare(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("beat %0d %s: got %0h, expected %0h",
                             beat_index, what, got, want));
    endtask

    task check_result(spq_pkg::t_rsp got);
        spq_pkg::t_rsp want;
        if (pending_snapshots.size() == 0) begin
            report($sformatf("result beat %0d with no operation pending", beat_index));
            beat_index++;
            return;
        end
        want = pending_snapshots.pop_front();
        compare("status",           got.status,           want.status);
        compare("removed_value",    got.removed_value,    want.removed_value);
        compare("front_value",      got.front_value,      want.front_value);
        compare("highest_priority", got.highest_priority, want.highest_priority);
        compare("lowest_priority",  got.lowest_priority,  want.lowest_priority);
        compare("occupancy",        got.occupancy,        want.occupancy);
        compare("is_empty",         got.is_empty,         want.is_empty);
        beat_index++;
    endtask

endclass

module stable_priority_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_unit #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sorted_queue_tracker #(QUEUE_DEPTH) tracker;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_request;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random ready, or a long hold-off when one is requested
    initial begin : receiver
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_request != 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // results first: a result beat never belongs to an operation taken on the same edge
    always @(posedge clk) begin : monitor
        spq_pkg::t_rsp seen;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.status           = rsp_ch.status;
                seen.removed_value    = rsp_ch.removed_value;
                seen.front_value      = rsp_ch.front_value;
                seen.highest_priority = rsp_ch.highest_priority;
                seen.lowest_priority  = rsp_ch.lowest_priority;
                seen.occupancy        = rsp_ch.occupancy;
                seen.is_empty         = rsp_ch.is_empty;
                tracker.check_result(seen);
            end
            if (req_ch.valid && req_ch.ready)
                tracker.note_operation(req_ch.kind, req_ch.value, req_ch.priority_req);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stable_priority_queue_unit regression: fail");
        $finish;
    end

    function automatic logic signed [31:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 6)) - 3;  // dense ties
            4, 5: begin
                case ($urandom_range(0, 3))
                    0:       return INT_MAX;
                    1:       return INT_MIN;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return INT_MAX;
            1:       return INT_MIN;
            2:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // offer one beat, idling first at the current sender rate, and hold until taken
    task send_op(logic kind, logic signed [31:0] value, logic signed [31:0] prio);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.value        <= value;
        req_ch.priority_req <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // first let the monitor note the last accepted beat, then wait for every pending result
    task pause_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // bursts with a fixed enqueue share swing the queue between empty and full
    task run_bursts(int n_ops);
        int done;
        int burst;
        int enq_pct;
        done = 0;
        while (done < n_ops) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            repeat (burst) begin
                if (done >= n_ops)
                    break;
                send_op(($urandom_range(0, 99) < enq_pct) ? spq_pkg::KIND_ENQ
                                                          : spq_pkg::KIND_DEQ,
                        pick_value(), pick_priority());
                done++;
            end
        end
    endtask

    initial begin : stimulus
        tracker             = new();
        tx_idle_pct         = 26;
        rx_idle_pct         = 69;
        rx_hold_request     = 0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = spq_pkg::KIND_ENQ;
        req_ch.value        = '0;
        req_ch.priority_req = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, extremes and ties, fill to capacity, overflow
        send_op(spq_pkg::KIND_DEQ, $urandom, $urandom);
        send_op(spq_pkg::KIND_ENQ, INT_MAX, 0);
        send_op(spq_pkg::KIND_ENQ, INT_MIN, 0);
        send_op(spq_pkg::KIND_ENQ, -1, INT_MAX);
        send_op(spq_pkg::KIND_ENQ, 0, INT_MIN);
        send_op(spq_pkg::KIND_ENQ, 1, INT_MIN);
        send_op(spq_pkg::KIND_ENQ, 2, -1);
        send_op(spq_pkg::KIND_ENQ, 3, 1);
        send_op(spq_pkg::KIND_ENQ, 4, INT_MAX);
        for (int k = 0; k < 8; k++)
            send_op(spq_pkg::KIND_ENQ, 32'sh5a5a0000 + k, (k % 3) - 1);
        send_op(spq_pkg::KIND_ENQ, 32'sh12345678, INT_MAX);
        repeat (5)
            send_op(spq_pkg::KIND_DEQ, $urandom, $urandom);

        run_bursts(475);
        pause_until_drained();

        tx_idle_pct = 69;
        rx_idle_pct = 26;
        run_bursts(475);
        pause_until_drained();

        // no idling; receiver stalls long enough to back up the input
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_request = 80;
        run_bursts(480);
        pause_until_drained();

        repeat (8) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("stable_priority_queue_unit regression: pass");
        else
            $display("stable_priority_queue_unit regression: fail");
        $finish;
    end

endmodule
